// File: hw/rtl/msp_pkg.sv
// Shared types, constants and helpers for the message padder.
package msp_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int POS_W       = $clog2(BLOCK_WORDS);
    localparam int ADDR_W      = 3;

    localparam logic [7:0]       MARK_BYTE  = 8'h80;
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(BLOCK_WORDS - 2);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(BLOCK_WORDS - 1);

    localparam logic REG_WORD_MODE  = 1'b0;
    localparam logic REG_BYTE_ORDER = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_ZERO,
        S_LEN_HI,
        S_LEN_LO
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic load_mark;
        logic clr;
    } pack_ctl_t;

    typedef struct packed {
        logic inc;
        logic clr;
    } len_ctl_t;

    function automatic logic [2:0] slot_lane(input logic       word_mode,
                                             input logic       byte_order,
                                             input logic [2:0] k);
        logic [2:0] lane;
        if (word_mode)
            lane = 3'd7 - k;
        else if (byte_order)
            lane = {1'b0, k[1:0]};
        else
            lane = {1'b0, 2'd3 - k[1:0]};
        return lane;
    endfunction

endpackage

// File: hw/rtl/msp_pack.sv
// Byte packing register: drops one byte digit per cycle into its word lane.
module msp_pack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              word_mode,
    input  logic              byte_order,
    input  msp_pkg::pack_ctl_t ctl,
    input  logic [7:0]        in_byte,
    output logic              word_full,
    output logic [63:0]       word_now
);
    import msp_pkg::*;

    logic [63:0] accum_reg;
    logic [63:0] accum_next;
    logic [2:0]  bic_reg;
    logic [2:0]  bic_next;
    logic [2:0]  k;
    logic [2:0]  lane;
    logic [3:0]  bpw;
    logic [3:0]  count;
    logic [7:0]  digit;
    logic        wr;

    assign k     = word_mode ? bic_reg : {1'b0, bic_reg[1:0]};
    assign lane  = slot_lane(word_mode, byte_order, k);
    assign bpw   = word_mode ? 4'd8 : 4'd4;
    assign count = {1'b0, k} + 4'd1;
    assign digit = ctl.load_mark ? MARK_BYTE : in_byte;
    assign wr    = ctl.load_byte | ctl.load_mark;

    assign word_full = (count == bpw);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_now[i*8 +: 8] = accum_reg[i*8 +: 8]
                               | ((wr && lane == 3'(i)) ? digit : 8'h00);
        end
    end

    always_comb
    begin
        accum_next = word_now;
        bic_next   = bic_reg;
        if (ctl.clr)
        begin
            accum_next = '0;
            bic_next   = '0;
        end
        else if (ctl.load_byte)
        begin
            bic_next = count[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            bic_reg   <= '0;
        end
        else
        begin
            accum_reg <= accum_next;
            bic_reg   <= bic_next;
        end
    end

endmodule

// File: hw/rtl/msp_len.sv
// Message bit length counter, modulo 2^64.
module msp_len (
    input  logic             clk,
    input  logic             rst_n,
    input  msp_pkg::len_ctl_t ctl,
    output logic [63:0]      bit_length
);
    import msp_pkg::*;

    logic [60:0] bytes_reg;
    logic [60:0] bytes_next;

    always_comb
    begin
        bytes_next = bytes_reg;
        if (ctl.clr)
            bytes_next = '0;
        else if (ctl.inc)
            bytes_next = bytes_reg + 61'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bytes_reg <= '0;
        else
            bytes_reg <= bytes_next;
    end

    assign bit_length = {bytes_reg, 3'b000};

endmodule

// File: hw/rtl/msp_ctrl.sv
// Padding sequencer, word position counter and output register.
module msp_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      word_mode,
    input  logic                      byte_order,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      has_byte,
    input  logic                      in_last,
    input  logic                      word_full,
    input  logic [63:0]               word_now,
    input  logic [63:0]               bit_length,
    output msp_pkg::pack_ctl_t        pack_ctl,
    output msp_pkg::len_ctl_t         len_ctl,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [63:0]               out_word,
    output logic [msp_pkg::POS_W-1:0] word_index,
    output logic                      msg_end
);
    import msp_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] pos_inc_val;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [63:0]      out_word_reg;
    logic [POS_W-1:0] out_index_reg;
    logic             out_end_reg;

    logic             out_free;
    logic             accept;
    logic             emit;
    logic [63:0]      emit_word;
    logic [63:0]      emit_masked;
    logic [POS_W-1:0] emit_idx;
    logic             emit_end;
    logic             pos_inc;
    logic             pos_clr;
    logic [63:0]      len_hi_word;
    logic [63:0]      len_lo_word;

    assign out_free    = !out_valid_reg || !out_stall;
    assign accept      = in_valid && (state_reg == S_IDLE) && out_free;
    assign in_stall    = !((state_reg == S_IDLE) && out_free);
    assign pos_inc_val = pos_reg + POS_W'(1);

    always_comb
    begin
        if (word_mode)
        begin
            len_hi_word = '0;
            len_lo_word = bit_length;
        end
        else if (byte_order)
        begin
            len_hi_word = {32'b0, bit_length[31:0]};
            len_lo_word = {32'b0, bit_length[63:32]};
        end
        else
        begin
            len_hi_word = {32'b0, bit_length[63:32]};
            len_lo_word = {32'b0, bit_length[31:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_last)
                    state_next = S_MARK;
            end
            S_MARK, S_ZERO:
            begin
                if (out_free)
                    state_next = (pos_inc_val == POS_LEN_HI) ? S_LEN_HI : S_ZERO;
            end
            S_LEN_HI:
            begin
                if (out_free)
                    state_next = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_word = '0;
        emit_idx  = pos_reg;
        emit_end  = 1'b0;
        pack_ctl  = '0;
        len_ctl   = '0;
        pos_inc   = 1'b0;
        pos_clr   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pack_ctl.load_byte = has_byte;
                    len_ctl.inc        = has_byte;
                    if (has_byte && word_full)
                    begin
                        emit         = 1'b1;
                        emit_word    = word_now;
                        pack_ctl.clr = 1'b1;
                        pos_inc      = 1'b1;
                    end
                end
            end
            S_MARK:
            begin
                if (out_free)
                begin
                    pack_ctl.load_mark = 1'b1;
                    pack_ctl.clr       = 1'b1;
                    emit               = 1'b1;
                    emit_word          = word_now;
                    pos_inc            = 1'b1;
                end
            end
            S_ZERO:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    pos_inc = 1'b1;
                end
            end
            S_LEN_HI:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_word = len_hi_word;
                    emit_idx  = POS_LEN_HI;
                end
            end
            S_LEN_LO:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    emit_word    = len_lo_word;
                    emit_idx     = POS_LEN_LO;
                    emit_end     = 1'b1;
                    pack_ctl.clr = 1'b1;
                    len_ctl.clr  = 1'b1;
                    pos_clr      = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign emit_masked = word_mode ? emit_word : {32'b0, emit_word[31:0]};

    always_comb
    begin
        pos_next = pos_reg;
        if (pos_clr)
            pos_next = '0;
        else if (pos_inc)
            pos_next = pos_inc_val;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_word_reg  <= emit_masked;
            out_index_reg <= emit_idx;
            out_end_reg   <= emit_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign word_index = out_index_reg;
    assign msg_end    = out_end_reg;

    a_end_at_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_index_reg == POS_LEN_LO)
        else $error("message end flagged away from the last block word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && out_valid_reg && out_stall))
        else $error("output register loaded while its word is stalled");

    a_stall_while_padding: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken during the padding burst");

    a_block_closes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LEN_LO && out_free |=> state_reg == S_IDLE && pos_reg == '0)
        else $error("block not closed after the length word");

    a_len_hi_position: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LEN_HI |-> pos_reg == POS_LEN_HI)
        else $error("length words reached at the wrong block position");

endmodule

// File: hw/rtl/md_sha_message_padder_unit.sv
// Top level of the MD5 / SHA-2 message padder with its register port.
//
//  channel   direction  handshake          payload
//  in        sink       in_valid/in_stall  in_byte, has_byte, in_last
//  out       source     out_valid/out_stall out_word, word_index, msg_end
//  cfg       APB slave  psel/penable/pready word_mode @0x0, byte_order @0x4
//
// One byte is taken per cycle unless stalled; a word leaves when its last byte lands.
// A final transaction starts a padding burst of 3 to 18 words, set by the sequencer
// walking the word position up to the length words, one per cycle unless stalled.
// Input stalls for the whole burst and whenever the output register is held.
// Reset clears the packing register, length counter, position and mode bits.
module md_sha_message_padder_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 in_byte,
    input  logic                       has_byte,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [63:0]                out_word,
    output logic [msp_pkg::POS_W-1:0]  word_index,
    output logic                       msg_end
);
    import msp_pkg::*;

    logic        word_mode_reg;
    logic        word_mode_next;
    logic        byte_order_reg;
    logic        byte_order_next;
    logic        wr_en;
    logic        reg_sel;
    pack_ctl_t   pack_ctl;
    len_ctl_t    len_ctl;
    logic        word_full;
    logic [63:0] word_now;
    logic [63:0] bit_length;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        word_mode_next  = word_mode_reg;
        byte_order_next = byte_order_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_WORD_MODE:  word_mode_next  = pwdata[0];
                REG_BYTE_ORDER: byte_order_next = pwdata[0];
                default:        word_mode_next  = word_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_WORD_MODE:  prdata = {31'b0, word_mode_reg};
            REG_BYTE_ORDER: prdata = {31'b0, byte_order_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_mode_reg  <= 1'b0;
            byte_order_reg <= 1'b0;
        end
        else
        begin
            word_mode_reg  <= word_mode_next;
            byte_order_reg <= byte_order_next;
        end
    end

    msp_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_mode  (word_mode_reg),
        .byte_order (byte_order_reg),
        .ctl        (pack_ctl),
        .in_byte    (in_byte),
        .word_full  (word_full),
        .word_now   (word_now)
    );

    msp_len u_len (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (len_ctl),
        .bit_length (bit_length)
    );

    msp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_mode  (word_mode_reg),
        .byte_order (byte_order_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .has_byte   (has_byte),
        .in_last    (in_last),
        .word_full  (word_full),
        .word_now   (word_now),
        .bit_length (bit_length),
        .pack_ctl   (pack_ctl),
        .len_ctl    (len_ctl),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .word_index (word_index),
        .msg_end    (msg_end)
    );

endmodule
